[rtl/pecg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pecg_pkg: shared types and constants of the peaking EQ coefficient generator
// Holds the band descriptor, the request and response bundles of the shared
// divider and the square-root unit, fixed-point constants and saturation.
// ----------------------------------------------------------------------------
package pecg_pkg;

  // Default number of equalizer bands
  localparam int MAX_BANDS_DEF = 8;

  // Configuration register indexes
  localparam logic REG_EQ_ENABLED  = 1'b0;
  localparam logic REG_SAMPLE_RATE = 1'b1;

  // Fixed-point constants
  localparam logic [17:0] SAMPLE_RATE_RST = 18'd48000;
  localparam logic [17:0] HALF_PI_Q15     = 18'd51471;   // pi in Q15, halved
  localparam logic [17:0] PI_Q15          = 18'd102943;
  localparam logic [19:0] PI_SQ_Q15       = 20'd323402;  // (pi * pi) >> 15
  localparam logic [16:0] HALF_TURN       = 17'd32768;
  localparam logic [19:0] GAIN_SPAN       = 20'd200;
  localparam logic signed [8:0] GAIN_MAX  = 9'sd200;
  localparam logic signed [8:0] GAIN_MIN  = -9'sd200;

  // Divider widths
  localparam int DIV_NW = 40;
  localparam int DIV_DW = 20;

  // One band as it arrives on the input stream
  typedef struct packed {
    logic [7:0]        band_q;
    logic signed [8:0] band_gain;
    logic [15:0]       band_freq;
    logic              band_on;
    logic [2:0]        band_index;
  } band_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] root;
  } sqrt_rsp_t;

  // Clamp a wide signed value to the Q15 range
  function automatic logic signed [15:0] sat16(input logic signed [41:0] x);
    logic signed [15:0] r;
    if (x > 42'sd32767) begin
      r = 16'sh7FFF;
    end else if (x < -42'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/pecg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pecg_div: shared restoring divider
// Unsigned 40-by-20 bit division, one quotient bit per cycle. The quotient
// is valid with the done pulse.
// ----------------------------------------------------------------------------
module pecg_div
  import pecg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic [5:0]        cnt;
  logic [DIV_NW-1:0] quot;
  logic [DIV_DW-1:0] divisor;
  logic [DIV_DW:0]   rem;
  logic              done;

  logic [DIV_DW:0]   rem_sh;
  logic              fits;

  // One restoring step
  always_comb begin
    rem_sh = {rem[DIV_DW-1:0], quot[DIV_NW-1]};
    fits   = rem_sh >= {1'b0, divisor};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 6'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot    <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      rem  <= fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
      quot <= {quot[DIV_NW-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

[rtl/pecg_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pecg_sqrt: integer square root
// Digit-by-digit floor square root of a 32-bit value, one result bit per
// cycle. The root is valid with the done pulse.
// ----------------------------------------------------------------------------
module pecg_sqrt
  import pecg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  logic        busy;
  logic [4:0]  cnt;
  logic        done;
  logic [31:0] rad;
  logic [17:0] rem;
  logic [15:0] root;

  logic [17:0] rem_sh;
  logic [17:0] trial;
  logic        fits;

  always_comb begin
    rem_sh = {rem[15:0], rad[31:30]};
    trial  = {root, 2'b01};
    fits   = rem_sh >= trial;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 5'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[29:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[14:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

[rtl/pecg_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pecg_core: coefficient sequencer
// Steps one band through the sine, alpha, amplitude and normalization
// computations on one shared multiplier, the shared divider and the square
// root unit, then streams the five coefficients.
// ----------------------------------------------------------------------------
module pecg_core
  import pecg_pkg::*;
#(
  parameter int MAX_BANDS = MAX_BANDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               eq_enabled,
  input  logic [17:0]        sample_rate,
  input  logic               in_valid,
  output logic               in_ready,
  input  band_t              band_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         coeff_index,
  output logic signed [15:0] coeff_value,
  output logic               last_coeff
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_W0      = 4'd1;
  localparam logic [3:0] ST_SIN_CHK = 4'd2;
  localparam logic [3:0] ST_SIN_TH  = 4'd3;
  localparam logic [3:0] ST_SIN_NUM = 4'd4;
  localparam logic [3:0] ST_SIN_DIV = 4'd5;
  localparam logic [3:0] ST_SIN_END = 4'd6;
  localparam logic [3:0] ST_MSW     = 4'd7;
  localparam logic [3:0] ST_MCW     = 4'd8;
  localparam logic [3:0] ST_ALPHA   = 4'd9;
  localparam logic [3:0] ST_A2      = 4'd10;
  localparam logic [3:0] ST_SQRT    = 4'd11;
  localparam logic [3:0] ST_AA      = 4'd12;
  localparam logic [3:0] ST_ADA     = 4'd13;
  localparam logic [3:0] ST_FIN     = 4'd14;
  localparam logic [3:0] ST_EMIT    = 4'd15;

  logic [3:0]  state;
  logic        pend;
  logic [2:0]  band;
  logic        gneg;
  logic [7:0]  gmag;
  logic [7:0]  qf;
  logic [16:0] half;
  logic [16:0] ang;
  logic        sphase;
  logic [16:0] sin_res;
  logic [16:0] sh;
  logic [16:0] ch;
  logic [35:0] prod;
  logic [15:0] sw0;
  logic signed [15:0] cw0;
  logic [17:0] alpha;
  logic [16:0] a2sq;
  logic [15:0] amp;
  logic [15:0] alpha_a;
  logic [17:0] alpha_div;
  logic [2:0]  k;
  logic signed [15:0] res [5];

  // Frequency held for the first division
  logic [15:0] band_in_freq_q;

  div_req_t  dreq;
  div_rsp_t  drsp;
  sqrt_req_t sreq;
  sqrt_rsp_t srsp;

  logic [17:0] mul_a;
  logic [17:0] mul_b;
  logic [16:0] th;
  logic signed [8:0] gain_sat;
  logic signed [41:0] num_s;
  logic signed [41:0] num_mag;
  logic signed [15:0] a0;
  logic signed [41:0] m2c;
  logic signed [41:0] quot_s;
  logic [32:0] half_raw;

  pecg_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  pecg_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sreq), .rsp(srsp));

  // Input gain clamped to the supported range
  always_comb begin
    if (band_in.band_gain > GAIN_MAX) begin
      gain_sat = GAIN_MAX;
    end else if (band_in.band_gain < GAIN_MIN) begin
      gain_sat = GAIN_MIN;
    end else begin
      gain_sat = band_in.band_gain;
    end
  end

  // Shared multiplier operands
  assign th = prod[31:15];
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SIN_TH: begin
        mul_a = {1'b0, ang};
        mul_b = HALF_PI_Q15;
      end
      ST_SIN_NUM: begin
        mul_a = {1'b0, th};
        mul_b = PI_Q15 - {1'b0, th};
      end
      ST_MSW: begin
        mul_a = {1'b0, sh};
        mul_b = {1'b0, ch};
      end
      ST_MCW: begin
        mul_a = {1'b0, sh};
        mul_b = {1'b0, sh};
      end
      ST_AA: begin
        mul_a = alpha;
        mul_b = {2'b00, amp};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Numerators of the normalized coefficients and the common a0
  always_comb begin
    m2c = -42'sd2 * 42'(cw0);
    a0  = sat16(42'sd32768 + $signed({24'b0, alpha_div}));
    case (k)
      3'd0:    num_s = 42'(sat16(42'sd32768 + $signed({26'b0, alpha_a})));
      3'd1:    num_s = 42'(sat16(m2c));
      3'd2:    num_s = 42'(sat16(42'sd32768 - $signed({26'b0, alpha_a})));
      3'd3:    num_s = m2c;
      default: num_s = 42'sd32768 - $signed({24'b0, alpha_div});
    endcase
    num_mag = (num_s < 0) ? -num_s : num_s;
    quot_s  = $signed({2'b00, drsp.quot});
  end

  // Requests to the divider and the square-root unit
  always_comb begin
    dreq     = '0;
    sreq     = '0;
    half_raw = drsp.quot[32:0];
    if (!pend) begin
      case (state)
        ST_W0: begin
          dreq.start    = 1'b1;
          dreq.dividend = {8'b0, band_in_freq_q, 16'b0};
          dreq.divisor  = {2'b00, sample_rate};
        end
        ST_SIN_DIV: begin
          dreq.start    = 1'b1;
          dreq.dividend = {2'b00, prod[35:13], 15'b0};
          dreq.divisor  = PI_SQ_Q15;
        end
        ST_ALPHA: begin
          dreq.start    = (qf != 8'd0);
          dreq.dividend = 40'({sw0, 3'b000}) + 40'({sw0, 1'b0});
          dreq.divisor  = {11'b0, qf, 1'b0};
        end
        ST_A2: begin
          dreq.start    = 1'b1;
          dreq.dividend = {17'b0, gmag, 15'b0};
          dreq.divisor  = GAIN_SPAN;
        end
        ST_SQRT: begin
          sreq.start    = 1'b1;
          sreq.radicand = {a2sq, 15'b0};
        end
        ST_ADA: begin
          dreq.start    = (amp != 16'd0);
          dreq.dividend = {7'b0, alpha, 15'b0};
          dreq.divisor  = {4'b0, amp};
        end
        ST_FIN: begin
          dreq.start    = 1'b1;
          dreq.dividend = {7'b0, num_mag[17:0], 15'b0};
          dreq.divisor  = {4'b0, a0};
        end
        default: begin
          dreq = '0;
          sreq = '0;
        end
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
      k     <= '0;
    end else begin
      if (dreq.start || sreq.start) begin
        pend <= 1'b1;
      end else if (drsp.done || srsp.done) begin
        pend <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && (int'(band_in.band_index) < MAX_BANDS)) begin
            k <= '0;
            if (!eq_enabled) begin
              state <= ST_EMIT;
            end else if (band_in.band_on && (band_in.band_freq != 16'd0) &&
                         (sample_rate != 18'd0)) begin
              state <= ST_W0;
            end
          end
        end
        ST_W0:      if (drsp.done) state <= ST_SIN_CHK;
        ST_SIN_CHK: begin
          if ((ang == 17'd0) || (ang >= HALF_TURN)) begin
            state <= ST_SIN_END;
          end else begin
            state <= ST_SIN_TH;
          end
        end
        ST_SIN_TH:  state <= ST_SIN_NUM;
        ST_SIN_NUM: state <= ST_SIN_DIV;
        ST_SIN_DIV: if (drsp.done) state <= ST_SIN_END;
        ST_SIN_END: state <= sphase ? ST_MSW : ST_SIN_CHK;
        ST_MSW:     state <= ST_MCW;
        ST_MCW:     state <= ST_ALPHA;
        ST_ALPHA: begin
          if ((!pend && (qf == 8'd0)) || drsp.done) state <= ST_A2;
        end
        ST_A2:      if (drsp.done) state <= ST_SQRT;
        ST_SQRT:    if (srsp.done) state <= ST_AA;
        ST_AA:      state <= ST_ADA;
        ST_ADA: begin
          if ((!pend && (amp == 16'd0)) || drsp.done) state <= ST_FIN;
        end
        ST_FIN: begin
          if (drsp.done) begin
            if (k == 3'd4) begin
              k     <= '0;
              state <= ST_EMIT;
            end else begin
              k <= k + 3'd1;
            end
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            if (k == 3'd4) begin
              state <= ST_IDLE;
            end else begin
              k <= k + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        band           <= band_in.band_index;
        band_in_freq_q <= band_in.band_freq;
        gneg           <= gain_sat[8];
        gmag           <= gain_sat[8] ? 8'(-gain_sat) : gain_sat[7:0];
        qf             <= band_in.band_q;
        sphase         <= 1'b0;
        res[0]         <= 16'sh7FFF;
        for (int i = 1; i < 5; i++) begin
          res[i] <= '0;
        end
      end
      ST_W0: begin
        if (drsp.done) begin
          if (half_raw[32:1] > {15'b0, HALF_TURN}) begin
            half <= HALF_TURN;
            ang  <= HALF_TURN;
          end else begin
            half <= half_raw[17:1];
            ang  <= half_raw[17:1];
          end
        end
      end
      ST_SIN_CHK: begin
        sin_res <= (ang == 17'd0) ? 17'd0 : 17'd32767;
      end
      ST_SIN_TH, ST_SIN_NUM, ST_MSW, ST_AA: begin
        prod <= mul_a * mul_b;
      end
      ST_SIN_DIV: begin
        if (drsp.done) sin_res <= drsp.quot[16:0];
      end
      ST_SIN_END: begin
        // Sine of the half angle first, then its cosine as the sine of the rest
        if (!sphase) begin
          sh     <= sin_res;
          sphase <= 1'b1;
          ang    <= HALF_TURN - half;
        end else begin
          ch <= sin_res;
        end
      end
      ST_MCW: begin
        sw0  <= sat16(42'({prod[35:15], 1'b0}));
        prod <= mul_a * mul_b;
      end
      ST_ALPHA: begin
        if (!pend) begin
          cw0 <= sat16(42'sd32768 - $signed({5'b0, prod[35:15], 1'b0}));
          if (qf == 8'd0) alpha <= {2'b00, sw0};
        end else if (drsp.done) begin
          alpha <= drsp.quot[17:0];
        end
      end
      ST_A2: begin
        if (drsp.done) begin
          a2sq <= gneg ? (HALF_TURN - drsp.quot[16:0]) : (HALF_TURN + drsp.quot[16:0]);
        end
      end
      ST_SQRT: begin
        if (srsp.done) amp <= srsp.root[15] ? 16'd32767 : srsp.root;
      end
      ST_ADA: begin
        if (!pend) begin
          alpha_a <= sat16(42'(prod[35:15]));
          if (amp == 16'd0) alpha_div <= alpha;
        end else if (drsp.done) begin
          alpha_div <= {2'b00, sat16(quot_s)};
        end
      end
      ST_FIN: begin
        if (drsp.done) res[k] <= sat16((num_s < 0) ? -quot_s : quot_s);
      end
      default: begin
      end
    endcase
  end

  // Output side
  assign in_ready    = (state == ST_IDLE);
  assign out_valid   = (state == ST_EMIT);
  assign coeff_index = 6'({3'b000, band} * 6'd5) + {3'b000, k};
  assign coeff_value = res[k];
  assign last_coeff  = (k == 3'd4);

endmodule

[rtl/peaking_eq_coeff_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peaking_eq_coeff_generator: peaking EQ biquad coefficient generator
// Turns one equalizer band description into five Q15 coefficient writes.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one band per transfer. The master stream returns
//   the coefficients b0, b1, b2, a1, a2 at index band*5+k, with tlast on a2.
//   Registers eq_enabled and sample_rate are written through the cfg port;
//   the user does so only while no band is in flight; this is not enforced.
//   With the equalizer off a band gives the identity set in the cycle
//   after its transfer. With it on, a band goes through up to eleven
//   divisions on the shared divider, a square root and the multiply steps
//   before its first coefficient. The five result transfers follow, one per
//   cycle while m_tready is high. Bands past MAX_BANDS give no output, nor
//   do disabled or zero-frequency bands or a zero sample rate, equalizer on.
//   s_tready is high only while the block is idle; a stalled master stream
//   holds the current coefficient until it is taken.
//   Reset (synchronous) returns to idle, turns the equalizer off and sets the
//   sample rate to 48000 Hz.
// ----------------------------------------------------------------------------
module peaking_eq_coeff_generator
  import pecg_pkg::*;
#(
  parameter int MAX_BANDS = MAX_BANDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // band_index[2:0], band_on[3], band_freq[19:4], band_gain[28:20], band_q[36:29]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // coeff_index[5:0], coeff_value[21:6]
  output logic [23:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [17:0] cfg_wdata
);

  logic        eq_enabled;
  logic [17:0] sample_rate;
  band_t       band_in;
  logic [5:0]  coeff_index;
  logic signed [15:0] coeff_value;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      eq_enabled  <= 1'b0;
      sample_rate <= SAMPLE_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_EQ_ENABLED:  eq_enabled  <= cfg_wdata[0];
        REG_SAMPLE_RATE: sample_rate <= cfg_wdata;
        default:         eq_enabled  <= eq_enabled;
      endcase
    end
  end

  // Unpack the band descriptor
  assign band_in = s_tdata[36:0];

  pecg_core #(.MAX_BANDS(MAX_BANDS)) u_core (
    .clk         (clk),
    .rst         (rst),
    .eq_enabled  (eq_enabled),
    .sample_rate (sample_rate),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .band_in     (band_in),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .coeff_index (coeff_index),
    .coeff_value (coeff_value),
    .last_coeff  (m_tlast)
  );

  assign m_tdata = {2'b00, coeff_value, coeff_index};

  // One band at a time: no new band while coefficients are pending
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input accepted while coefficients pending");

  // A coefficient set is streamed without gaps until its last transfer
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("gap inside a coefficient burst");

  // With the equalizer off an in-range band is answered in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !eq_enabled && (int'(s_tdata[2:0]) < MAX_BANDS))
      |=> (m_tvalid && (m_tdata[21:6] == 16'h7FFF)))
    else $error("identity set not produced");

endmodule

[tb/tb_peaking_eq_coeff_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peaking_eq_coeff_generator: self-checking bench for the coefficient unit
// Bands are sent over the slave stream with random gaps. Every accepted band
// is run through a bit-exact model of the fixed-point math, and each master
// transfer is compared with the oldest predicted coefficient write. The run
// covers the equalizer on and off and several sample rates, the extremes too.
// ----------------------------------------------------------------------------
module tb_peaking_eq_coeff_generator
  import pecg_pkg::*;
;

  typedef struct {
    logic [5:0]         idx;
    logic signed [15:0] value;
    logic               last;
  } coeff_wr_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [17:0] cfg_wdata = '0;

  band_t     band_queue[$];
  coeff_wr_t coeff_queue[$];
  band_t     band_cur;
  int        send_gap = 0;
  int        recv_stall = 0;
  int        error_count = 0;
  bit        calm = 1'b0;

  // Shadow copy of the configuration registers
  bit          eq_on_m = 1'b0;
  logic [17:0] rate_m = SAMPLE_RATE_RST;

  peaking_eq_coeff_generator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> 15;
  endfunction

  function automatic longint isqrt(longint n);
    longint x, y;
    if (n == 0) return 0;
    x = n;
    y = (x + 1) >> 1;
    while (y < x) begin
      x = y;
      y = (x + n / x) >> 1;
    end
    return x;
  endfunction

  // Parabolic sine, where 32768 stands for a quarter turn
  function automatic longint para_sine(longint ang);
    longint th, num, den;
    if (ang == 0) return 0;
    if (ang >= 32768) return 32767;
    th = (ang * 51471) >> 15;
    num = (4 * th * (102943 - th)) >> 15;
    den = (longint'(102943) * 102943) >> 15;
    return (num * 32768) / den;
  endfunction

  function automatic void push_coeff(int band, int k, longint v);
    coeff_wr_t w;
    w.idx = 6'(band * 5 + k);
    w.value = 16'(v);
    w.last = (k == 4);
    coeff_queue.push_back(w);
  endfunction

  // Predict the coefficient writes that one band causes
  function automatic void predict_band(band_t b);
    longint g, w0, half, sh, ch, sw0, cw0, alpha, a2sq, amp, alpha_a, alpha_div;
    longint b0, b1, b2, a0, m2c;
    if (int'(b.band_index) >= MAX_BANDS_DEF) return;
    if (!eq_on_m) begin
      for (int k = 0; k < 5; k++) push_coeff(b.band_index, k, (k == 0) ? 32767 : 0);
      return;
    end
    if (!b.band_on || b.band_freq == 0 || rate_m == 0) return;
    g = longint'(b.band_gain);
    if (g > 200) g = 200;
    if (g < -200) g = -200;
    w0 = (longint'(b.band_freq) * 65536) / longint'(rate_m);
    half = w0 >> 1;
    if (half > 32768) half = 32768;
    sh = para_sine(half);
    ch = (half >= 32768) ? 0 : para_sine(32768 - half);
    sw0 = clamp16(2 * fx_mul(sh, ch));
    cw0 = clamp16(32768 - 2 * fx_mul(sh, sh));
    alpha = (b.band_q > 0) ? (sw0 * 10) / (2 * longint'(b.band_q)) : sw0;
    a2sq = 32768 + (g * 32768) / 200;
    amp = clamp16(isqrt(a2sq * 32768));
    alpha_a = clamp16(fx_mul(alpha, amp));
    alpha_div = (amp > 0) ? clamp16((alpha * 32768) / amp) : alpha;
    b0 = clamp16(32768 + alpha_a);
    m2c = -2 * cw0;
    b1 = clamp16(m2c);
    b2 = clamp16(32768 - alpha_a);
    a0 = clamp16(32768 + alpha_div);
    if (a0 == 0) return;
    push_coeff(b.band_index, 0, clamp16((b0 * 32768) / a0));
    push_coeff(b.band_index, 1, clamp16((b1 * 32768) / a0));
    push_coeff(b.band_index, 2, clamp16((b2 * 32768) / a0));
    push_coeff(b.band_index, 3, clamp16((m2c * 32768) / a0));
    push_coeff(b.band_index, 4, clamp16(((32768 - alpha_div) * 32768) / a0));
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Input driver: one band per transfer, random gap after each
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_band(band_cur);
        send_gap = calm ? 0 : $urandom_range(0, 10);
        if (send_gap == 0 && band_queue.size() != 0) begin
          band_cur = band_queue.pop_front();
          s_tdata <= 40'(band_cur);
        end else begin
          s_tvalid <= 1'b0;
        end
      end else if (!s_tvalid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (band_queue.size() != 0) begin
          band_cur = band_queue.pop_front();
          s_tdata <= 40'(band_cur);
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  // Output monitor with random back-pressure
  always @(posedge clk) begin
    coeff_wr_t w;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (coeff_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer %h last %b", m_tdata, m_tlast));
        end else begin
          w = coeff_queue.pop_front();
          if (m_tdata[5:0] !== w.idx)
            report_mismatch($sformatf("index %0d, expected %0d", m_tdata[5:0], w.idx));
          if ($signed(m_tdata[21:6]) !== w.value)
            report_mismatch($sformatf("value %0d, expected %0d at index %0d",
                                      $signed(m_tdata[21:6]), w.value, w.idx));
          if (m_tlast !== w.last)
            report_mismatch($sformatf("tlast %b, expected %b at index %0d",
                                      m_tlast, w.last, w.idx));
        end
        recv_stall = calm ? 0 : $urandom_range(0, 10);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Wait until the block is idle, with margin for bands that give no output
  task automatic drain();
    while (band_queue.size() != 0 || s_tvalid || coeff_queue.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [17:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_EQ_ENABLED) eq_on_m = data[0];
    else rate_m = data;
  endtask

  task automatic add_band(int idx, bit on, int freq, int gain, int q);
    band_t b;
    b.band_index = 3'(idx);
    b.band_on = on;
    b.band_freq = 16'(freq);
    b.band_gain = 9'(gain);
    b.band_q = 8'(q);
    band_queue.push_back(b);
  endtask

  // Mostly well-formed enabled bands, some noise
  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) != 0)
        add_band($urandom_range(0, 7), 1'b1, $urandom_range(1, 65535),
                 $urandom_range(0, 511), $urandom_range(0, 255));
      else
        add_band($urandom_range(0, 7), $urandom_range(0, 1),
                 ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 65535),
                 $urandom_range(0, 511), $urandom_range(0, 255));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Equalizer off after reset: identity for every band
    add_band(0, 1'b0, 0, 0, 0);
    add_band(7, 1'b1, 65535, -256, 255);
    add_band(3, 1'b0, 1000, 100, 7);
    drain();

    // Equalizer on at the reset rate: gain, Q and frequency extremes
    write_reg(REG_EQ_ENABLED, 18'd1);
    add_band(0, 1'b1, 1000, -200, 7);
    add_band(1, 1'b1, 1000, 200, 7);
    add_band(2, 1'b1, 1000, -256, 10);
    add_band(3, 1'b1, 1000, 255, 10);
    add_band(4, 1'b1, 1, 0, 0);
    add_band(5, 1'b1, 65535, 60, 255);
    add_band(6, 1'b1, 24000, -60, 1);
    add_band(7, 1'b1, 12000, 0, 255);
    add_band(2, 1'b0, 1000, 30, 7);
    add_band(2, 1'b1, 0, 30, 7);
    drain();

    // Lowest and highest sample rate
    write_reg(REG_SAMPLE_RATE, 18'd8000);
    add_band(1, 1'b1, 4000, 120, 14);
    add_band(6, 1'b1, 65535, -120, 3);
    drain();
    write_reg(REG_SAMPLE_RATE, 18'd192000);
    add_band(0, 1'b1, 20, 200, 255);
    add_band(7, 1'b1, 65535, -200, 0);
    drain();

    // Zero sample rate gives no output
    write_reg(REG_SAMPLE_RATE, 18'd0);
    add_band(4, 1'b1, 1000, 50, 7);
    add_band(5, 1'b1, 65535, -50, 0);
    drain();

    // Random phases over random settings, some without idling
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_SAMPLE_RATE, 18'($urandom_range(8000, 192000)));
      write_reg(REG_EQ_ENABLED, 18'((p % 3) != 2));
      calm = (p == 1) || (p == 4);
      add_random(20);
      drain();
    end
    calm = 1'b0;
    write_reg(REG_SAMPLE_RATE, 18'd48000);
    add_random(10);
    drain();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
